// File: design/hst_pkg.sv
// Shared types and constants for the handle slot table.
package hst_pkg;

  localparam int OP_W      = 2;
  localparam int HDL_W     = 8;
  localparam int IDX_OUT_W = 8;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_LOOK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;     // latch op and handle
    logic scan_first;   // start free scan at the hint word
    logic scan_next;    // advance free scan by one word
    logic commit_add;   // grant scanned handle
    logic commit_del;   // free handle, shrink dense range
    logic commit_move;  // move last dense entry into the gap
    logic res_lookup;
    logic res_full;
    logic res_bad;
    logic clr_start;
    logic clr_step;     // zero one in-use word
    logic res_clear;
    logic push;         // load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  req_op;
    logic range_ok;
    logic full;
    logic hdl_live;
    logic idx_ok;
    logic del_last;
    logic scan_hit;
    logic clr_last;
  } dp_status_t;

endpackage

// File: design/hst_ctrl.sv
// Sequencing state machine for the handle slot table.
module hst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hst_pkg::dp_status_t sts,
  output hst_pkg::dp_cmd_t    cmd
);
  import hst_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_DECODE, S_HCHK, S_MOVE, S_SCAN, S_CLR, S_PUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.req_op) inside
          OP_ADD: begin
            if (sts.full) begin
              cmd.res_full = 1'b1;
              state_nxt    = S_PUSH;
            end else begin
              cmd.scan_first = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          OP_DEL, OP_LOOK: begin
            if (!sts.range_ok) begin
              cmd.res_bad = 1'b1;
              state_nxt   = S_PUSH;
            end else begin
              state_nxt = S_HCHK;
            end
          end
          default: begin
            cmd.clr_start = 1'b1;
            state_nxt     = S_CLR;
          end
        endcase
      end
      S_HCHK: begin
        state_nxt = S_PUSH;
        if (!sts.hdl_live) begin
          cmd.res_bad = 1'b1;
        end else if (sts.req_op == OP_LOOK) begin
          cmd.res_lookup = 1'b1;
        end else if (!sts.idx_ok) begin
          cmd.res_bad = 1'b1;
        end else begin
          cmd.commit_del = 1'b1;
          if (!sts.del_last) state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd.commit_move = 1'b1;
        state_nxt       = S_PUSH;
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.commit_add = 1'b1;
          state_nxt      = S_PUSH;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.res_clear = 1'b1;
          state_nxt     = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) begin
          cmd.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: design/hst_datapath.sv
// Maps, in-use bitmap, counters and result registers of the handle slot table.
module hst_datapath #(
  parameter int CAPACITY = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [hst_pkg::OP_W-1:0]     in_op,
  input  logic [hst_pkg::HDL_W-1:0]    in_handle,
  input  hst_pkg::dp_cmd_t             cmd,
  output hst_pkg::dp_status_t          sts,
  output logic [hst_pkg::ST_W-1:0]      out_status,
  output logic [hst_pkg::HDL_W-1:0]     out_new_handle,
  output logic [hst_pkg::IDX_OUT_W-1:0] out_dense_index,
  output logic                          out_moved,
  output logic [hst_pkg::HDL_W-1:0]     out_moved_handle,
  output logic [hst_pkg::CNT_OUT_W-1:0] out_entry_count
);
  import hst_pkg::*;

  localparam int HW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int WORD_W = ((2 ** HW) < 32) ? (2 ** HW) : 32;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int NWORDS = (CAPACITY + WORD_W - 1) / WORD_W;
  localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int FHW    = WIDX_W + BIT_W;

  // storage
  logic [WORD_W-1:0] use_mem [NWORDS];
  logic [HW-1:0]     ioh_mem [CAPACITY];
  logic [HW-1:0]     hoi_mem [CAPACITY];

  logic [WORD_W-1:0] use_rd_r;
  logic [HW-1:0]     ioh_rd_r;
  logic [HW-1:0]     hoi_rd_r;

  // control state
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     hint_r, hint_nxt;
  logic [WIDX_W-1:0] ptr_r, ptr_nxt;

  // latched request and moved-entry index
  op_t               req_op_r;
  logic [HDL_W-1:0]  req_hdl_r;
  logic [HW-1:0]     idx_r;

  // result and output registers
  logic [ST_W-1:0]      res_status_r, out_status_r;
  logic [HDL_W-1:0]     res_newh_r, out_newh_r;
  logic [IDX_OUT_W-1:0] res_dix_r, out_dix_r;
  logic                 res_mv_r, out_mv_r;
  logic [HDL_W-1:0]     res_mh_r, out_mh_r;
  logic [CNT_OUT_W-1:0] res_cnt_r, out_cnt_r;

  logic [HW-1:0]     h_int;
  logic [FHW-1:0]    h_ext;
  logic [WIDX_W-1:0] h_word;
  logic [BIT_W-1:0]  h_bit;
  logic [WIDX_W-1:0] hint_word;
  logic [WIDX_W-1:0] ptr_inc;
  logic [WORD_W-1:0] free_bits;
  logic [BIT_W-1:0]  first_bit;
  logic [FHW-1:0]    new_k_ext;
  logic [HW-1:0]     new_k;
  logic [CW-1:0]     h_cw;
  logic [CW-1:0]     idx_cw;

  logic [WIDX_W-1:0] use_raddr, use_waddr;
  logic [WORD_W-1:0] use_wdata;
  logic              use_we;
  logic [HW-1:0]     ioh_waddr, ioh_wdata, hoi_waddr, hoi_wdata, hoi_raddr;
  logic              ioh_we, hoi_we;

  assign h_int     = HW'(req_hdl_r);
  assign h_ext     = FHW'(h_int);
  assign h_word    = h_ext[FHW-1:BIT_W];
  assign h_bit     = h_ext[BIT_W-1:0];
  assign h_cw      = CW'(h_int);
  assign idx_cw    = CW'(ioh_rd_r);
  assign hint_word = WIDX_W'(32'(hint_r) >> BIT_W);
  assign ptr_inc   = WIDX_W'(ptr_r + 1'b1);
  assign hoi_raddr = HW'(count_r - CW'(1));

  // lowest free handle in the scanned word; bits past capacity count as used
  always_comb begin
    free_bits = '0;
    first_bit = '0;
    for (int b = 0; b < WORD_W; b++) begin
      free_bits[b] = !use_rd_r[b] && (((32'(ptr_r) << BIT_W) + b) < CAPACITY);
    end
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) first_bit = BIT_W'(b);
    end
  end

  assign new_k_ext = {ptr_r, first_bit};
  assign new_k     = HW'(new_k_ext);

  always_comb begin
    sts.req_op   = req_op_r;
    sts.range_ok = (32'(req_hdl_r) < 32'(CAPACITY));
    sts.full     = (count_r == CW'(CAPACITY));
    sts.hdl_live = use_rd_r[h_bit];
    sts.idx_ok   = (idx_cw < count_r);
    sts.del_last = (idx_cw == CW'(count_r - CW'(1)));
    sts.scan_hit = |free_bits;
    sts.clr_last = (ptr_r == WIDX_W'(NWORDS - 1));
  end

  // memory port steering
  always_comb begin
    use_raddr = h_word;
    if (cmd.scan_first) begin
      use_raddr = hint_word;
    end else if (cmd.scan_next) begin
      use_raddr = ptr_inc;
    end

    use_we    = cmd.commit_add || cmd.commit_del || cmd.clr_step;
    use_waddr = cmd.commit_del ? h_word : ptr_r;
    use_wdata = '0;
    if (cmd.commit_add) begin
      use_wdata = use_rd_r | (WORD_W'(1) << first_bit);
    end else if (cmd.commit_del) begin
      use_wdata = use_rd_r & ~(WORD_W'(1) << h_bit);
    end

    ioh_we    = cmd.commit_add || cmd.commit_move;
    ioh_waddr = cmd.commit_add ? new_k : hoi_rd_r;
    ioh_wdata = cmd.commit_add ? HW'(count_r) : idx_r;

    hoi_we    = cmd.commit_add || cmd.commit_move;
    hoi_waddr = cmd.commit_add ? HW'(count_r) : idx_r;
    hoi_wdata = cmd.commit_add ? new_k : hoi_rd_r;
  end

  always_ff @(posedge clk) begin
    if (use_we) use_mem[use_waddr] <= use_wdata;
    use_rd_r <= use_mem[use_raddr];
  end

  always_ff @(posedge clk) begin
    if (ioh_we) ioh_mem[ioh_waddr] <= ioh_wdata;
    ioh_rd_r <= ioh_mem[h_int];
  end

  always_ff @(posedge clk) begin
    if (hoi_we) hoi_mem[hoi_waddr] <= hoi_wdata;
    hoi_rd_r <= hoi_mem[hoi_raddr];
  end

  always_comb begin
    count_nxt = count_r;
    hint_nxt  = hint_r;
    ptr_nxt   = ptr_r;
    if (cmd.commit_add) begin
      count_nxt = count_r + CW'(1);
      hint_nxt  = CW'(new_k) + CW'(1);
    end else if (cmd.commit_del) begin
      count_nxt = count_r - CW'(1);
      hint_nxt  = (h_cw < hint_r) ? h_cw : hint_r;
    end else if (cmd.clr_start) begin
      count_nxt = '0;
      hint_nxt  = '0;
    end
    if (cmd.scan_first) begin
      ptr_nxt = hint_word;
    end else if (cmd.scan_next || cmd.clr_step) begin
      ptr_nxt = ptr_inc;
    end else if (cmd.clr_start) begin
      ptr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      hint_r  <= '0;
      ptr_r   <= '0;
    end else begin
      count_r <= count_nxt;
      hint_r  <= hint_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op_r  <= op_t'(in_op);
      req_hdl_r <= in_handle;
    end
    if (cmd.commit_del) idx_r <= ioh_rd_r;

    if (cmd.res_full || cmd.res_bad || cmd.res_clear) begin
      res_status_r <= cmd.res_full ? ST_FULL : (cmd.res_bad ? ST_BAD : ST_OK);
      res_newh_r   <= '0;
      res_dix_r    <= '0;
      res_mv_r     <= 1'b0;
      res_mh_r     <= '0;
      res_cnt_r    <= cmd.res_clear ? '0 : CNT_OUT_W'(count_r);
    end
    if (cmd.res_lookup) begin
      res_status_r <= ST_OK;
      res_newh_r   <= '0;
      res_dix_r    <= IDX_OUT_W'(ioh_rd_r);
      res_mv_r     <= 1'b0;
      res_mh_r     <= '0;
      res_cnt_r    <= CNT_OUT_W'(count_r);
    end
    if (cmd.commit_add) begin
      res_status_r <= ST_OK;
      res_newh_r   <= HDL_W'(new_k);
      res_dix_r    <= IDX_OUT_W'(count_r);
      res_mv_r     <= 1'b0;
      res_mh_r     <= '0;
      res_cnt_r    <= CNT_OUT_W'(count_r + CW'(1));
    end
    if (cmd.commit_del) begin
      res_status_r <= ST_OK;
      res_newh_r   <= '0;
      res_dix_r    <= IDX_OUT_W'(ioh_rd_r);
      res_mv_r     <= 1'b0;
      res_mh_r     <= '0;
      res_cnt_r    <= CNT_OUT_W'(count_r - CW'(1));
    end
    if (cmd.commit_move) begin
      res_mv_r <= 1'b1;
      res_mh_r <= HDL_W'(hoi_rd_r);
    end

    if (cmd.push) begin
      out_status_r <= res_status_r;
      out_newh_r   <= res_newh_r;
      out_dix_r    <= res_dix_r;
      out_mv_r     <= res_mv_r;
      out_mh_r     <= res_mh_r;
      out_cnt_r    <= res_cnt_r;
    end
  end

  assign out_status       = out_status_r;
  assign out_new_handle   = out_newh_r;
  assign out_dense_index  = out_dix_r;
  assign out_moved        = out_mv_r;
  assign out_moved_handle = out_mh_r;
  assign out_entry_count  = out_cnt_r;

endmodule

// File: design/handle_slot_table_unit.sv
// Top level of the handle slot table: dense slot map with lowest-free handle grant.
//
// Usage: one request transaction on in_* (op, handle) yields exactly one
// response transaction on out_*. Add grants the lowest free handle and appends
// it at the next dense index; delete frees a handle and moves the last dense
// entry into the gap (out_moved / out_moved_handle report it); lookup returns
// the dense index of a live handle; clear empties the table.
// One request is in flight at a time: in_ready returns only after the previous
// request has loaded its response. A full table on add, or a handle past
// capacity, is answered straight from decode; lookup and delete check the
// handle first, and a delete that moves an entry takes an extra step. Add scans
// the in-use bitmap word by word (up to 32 handles per word; the scan starts at
// a lowest-free hint, so it is usually one word); clear zeroes it word by word.
// The cost is set by the single read port of the in-use bitmap and the
// dependent map reads of a delete. Reset (rst_n low, synchronous) empties the
// table; afterwards a bitmap clearing pass runs with in_ready low.
// The response sits in an output register: a new request is accepted while a
// response waits, and that request's own response holds until out_ready.
module handle_slot_table_unit #(
  parameter int CAPACITY = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hst_pkg::OP_W-1:0]      in_op,
  input  logic [hst_pkg::HDL_W-1:0]     in_handle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hst_pkg::ST_W-1:0]      out_status,
  output logic [hst_pkg::HDL_W-1:0]     out_new_handle,
  output logic [hst_pkg::IDX_OUT_W-1:0] out_dense_index,
  output logic                          out_moved,
  output logic [hst_pkg::HDL_W-1:0]     out_moved_handle,
  output logic [hst_pkg::CNT_OUT_W-1:0] out_entry_count
);
  import hst_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  // sequencing: request decode, map reads, commit, response push
  hst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // both maps, in-use bitmap, live count and response registers
  hst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_handle        (in_handle),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (out_status),
    .out_new_handle   (out_new_handle),
    .out_dense_index  (out_dense_index),
    .out_moved        (out_moved),
    .out_moved_handle (out_moved_handle),
    .out_entry_count  (out_entry_count)
  );

endmodule
